FILE: rtl/assert_macros.svh
// Assertion macros shared by the rotation matrix to quaternion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define RM2Q_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rm2q assertion failed");

// Next-cycle implication, checked at each rising edge outside reset.
`define RM2Q_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rm2q assertion failed");

`endif

FILE: rtl/rm2q_pkg.sv
// Shared types and constants of the rotation matrix to quaternion block.
`default_nettype none

package rm2q_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // Which diagonal element leads the conversion; trace case has none
   typedef enum logic [1:0] {
      PIV_X     = 2'd0,
      PIV_Y     = 2'd1,
      PIV_Z     = 2'd2,
      PIV_TRACE = 2'd3
   } pivot_type;

   // Control that travels with each transaction down the pipeline
   typedef struct packed {
      logic      valid;
      pivot_type sel;
      logic [2:0] neg;
   } ctl_type;

   localparam ctl_type CTL_IDLE = '{valid: 1'b0, sel: PIV_TRACE, neg: 3'b000};

endpackage

`default_nettype wire

FILE: rtl/rm2q_if.sv
// Request and response channel interfaces of the rotation matrix to quaternion block.
`default_nettype none

interface rm2q_req_if import rm2q_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
);
   localparam int IW = FRAC_BITS + 2;

   logic          valid;
   logic          ready;
   logic signed [IW-1:0] m00, m01, m02;
   logic signed [IW-1:0] m10, m11, m12;
   logic signed [IW-1:0] m20, m21, m22;

   modport source (
      output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
      input  ready
   );
   modport sink (
      input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
      output ready
   );
endinterface

interface rm2q_rsp_if import rm2q_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
);
   localparam int VW = FRAC_BITS + 2;
   localparam int WW = FRAC_BITS + 1;

   logic                 valid;
   logic                 ready;
   logic signed [VW-1:0] qx, qy, qz;
   logic        [WW-1:0] qw;
   logic                 clipped;

   modport source (
      output valid, qx, qy, qz, qw, clipped,
      input  ready
   );
   modport sink (
      input  valid, qx, qy, qz, qw, clipped,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter.
`default_nettype none
`include "assert_macros.svh"

// Converts a 3x3 direction cosine matrix (signed, FRAC_BITS fraction bits) into a
// quaternion with the scalar part last and non-negative, using the trace when it
// is positive and the largest diagonal pivot otherwise. One transaction enters per
// cycle unless the response stalls. The pipeline has one front stage, FRAC_BITS+2
// square root stages (one root bit each), 2*FRAC_BITS+2 divider stages (one
// quotient bit each, three lanes side by side) and one output stage.
// Back-pressure on the response freezes the whole pipeline, so request
// ready equals "output register empty or being taken".
module rotation_matrix_to_quaternion import rm2q_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rm2q_req_if.sink   req_if,
   rm2q_rsp_if.source rsp_if
);
   localparam logic signed [FRAC_BITS+1:0] ONE_VEC = (FRAC_BITS+2)'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS:0]          ONE_W   = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic                       en;
   logic signed [FRAC_BITS+1:0] m_in [9];
   ctl_type                    front_ctl;
   logic [FRAC_BITS+2:0]       front_rad;
   logic [FRAC_BITS+2:0]       front_mag [3];
   ctl_type                    sqrt_ctl;
   logic [FRAC_BITS+1:0]       sqrt_root;
   logic [FRAC_BITS+2:0]       sqrt_mag [3];
   ctl_type                    div_ctl;
   logic [FRAC_BITS+1:0]       div_r;
   logic [2*FRAC_BITS+1:0]     div_quo [3];

   // Advance the pipeline unless a finished result is held
   assign en           = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = en;

   assign m_in[0] = req_if.m00;
   assign m_in[1] = req_if.m01;
   assign m_in[2] = req_if.m02;
   assign m_in[3] = req_if.m10;
   assign m_in[4] = req_if.m11;
   assign m_in[5] = req_if.m12;
   assign m_in[6] = req_if.m20;
   assign m_in[7] = req_if.m21;
   assign m_in[8] = req_if.m22;

   rm2q_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_if.valid),
      .m_i      (m_in),
      .ctl_o    (front_ctl),
      .rad_o    (front_rad),
      .mag_o    (front_mag)
   );

   rm2q_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .ctl_i  (front_ctl),
      .rad_i  (front_rad),
      .mag_i  (front_mag),
      .ctl_o  (sqrt_ctl),
      .root_o (sqrt_root),
      .mag_o  (sqrt_mag)
   );

   rm2q_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .ctl_i (sqrt_ctl),
      .r_i   (sqrt_root),
      .mag_i (sqrt_mag),
      .ctl_o (div_ctl),
      .r_o   (div_r),
      .quo_o (div_quo)
   );

   rm2q_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_i     (div_ctl),
      .r_i       (div_r),
      .quo_i     (div_quo),
      .valid_o   (rsp_if.valid),
      .qx_o      (rsp_if.qx),
      .qy_o      (rsp_if.qy),
      .qz_o      (rsp_if.qz),
      .qw_o      (rsp_if.qw),
      .clipped_o (rsp_if.clipped)
   );

   // Check qx, qy inside plus or minus one, qw at most one, front stage tracks handshake
   `RM2Q_ASSERT_SAME(a_vec_range, clock, reset, rsp_if.valid, (rsp_if.qx <= ONE_VEC && rsp_if.qx >= -ONE_VEC && rsp_if.qy <= ONE_VEC && rsp_if.qy >= -ONE_VEC))
   `RM2Q_ASSERT_SAME(a_w_range, clock, reset, rsp_if.valid, (rsp_if.qw <= ONE_W))
   `RM2Q_ASSERT_NEXT(a_front_load, clock, reset, (req_if.valid && req_if.ready), front_ctl.valid)
   `RM2Q_ASSERT_NEXT(a_front_hold, clock, reset, !en, $stable(front_ctl))

endmodule

`default_nettype wire

FILE: rtl/rm2q_front.sv
// Front stage: trace test, pivot choice, radicand and off-diagonal numerators.
`default_nettype none

module rm2q_front import rm2q_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [FRAC_BITS+1:0] m_i [9],
   output ctl_type                 ctl_o,
   output logic [FRAC_BITS+2:0]    rad_o,
   output logic [FRAC_BITS+2:0]    mag_o [3]
);
   localparam int SW    = FRAC_BITS + 4;
   localparam int RAD_W = FRAC_BITS + 3;
   localparam int MAG_W = FRAC_BITS + 3;
   localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC_BITS;

   logic signed [SW-1:0] e [9];
   logic signed [SW-1:0] tr;
   logic signed [SW-1:0] rad_s;
   logic signed [SW-1:0] d [3];
   pivot_type            piv;
   ctl_type              ctl_in;
   logic [RAD_W-1:0]     rad_in;
   logic [MAG_W-1:0]     mag_in [3];
   ctl_type              ctl_ff;
   logic [RAD_W-1:0]     rad_ff;
   logic [MAG_W-1:0]     mag_ff [3];

   // Widen elements so sums cannot wrap
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         e[k] = SW'(m_i[k]);
      end
   end

   assign tr = e[0] + e[4] + e[8];

   // Choose pivot, radicand and numerators
   always_comb begin
      piv   = PIV_TRACE;
      rad_s = tr + ONE;
      d[0]  = e[5] - e[7];
      d[1]  = e[6] - e[2];
      d[2]  = e[1] - e[3];
      if (!(tr > 0)) begin
         piv = (e[4] > e[0]) ? PIV_Y : PIV_X;
         if (e[8] > ((piv == PIV_Y) ? e[4] : e[0])) begin
            piv = PIV_Z;
         end
         case (piv)
            PIV_X: begin
               rad_s = e[0] - e[4] - e[8] + ONE;
               d[0]  = e[5] - e[7];
               d[1]  = e[1] + e[3];
               d[2]  = e[2] + e[6];
            end
            PIV_Y: begin
               rad_s = e[4] - e[8] - e[0] + ONE;
               d[0]  = e[6] - e[2];
               d[1]  = e[5] + e[7];
               d[2]  = e[3] + e[1];
            end
            default: begin
               rad_s = e[8] - e[0] - e[4] + ONE;
               d[0]  = e[1] - e[3];
               d[1]  = e[6] + e[2];
               d[2]  = e[7] + e[5];
            end
         endcase
      end
   end

   // Clamp radicand, split numerators into sign and magnitude
   always_comb begin
      ctl_in.valid = in_valid;
      ctl_in.sel   = piv;
      rad_in       = (rad_s < 0) ? '0 : rad_s[RAD_W-1:0];
      for (int l = 0; l < 3; l++) begin
         ctl_in.neg[l] = d[l][SW-1];
         mag_in[l]     = d[l][SW-1] ? MAG_W'(-d[l]) : MAG_W'(d[l]);
      end
   end

   // Hold control on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= CTL_IDLE;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= rad_in;
         mag_ff <= mag_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign rad_o = rad_ff;
   assign mag_o = mag_ff;

endmodule

`default_nettype wire

FILE: rtl/rm2q_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module rm2q_sqrt import rm2q_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ctl_type              ctl_i,
   input  logic [FRAC_BITS+2:0] rad_i,
   input  logic [FRAC_BITS+2:0] mag_i [3],
   output ctl_type              ctl_o,
   output logic [FRAC_BITS+1:0] root_o,
   output logic [FRAC_BITS+2:0] mag_o [3]
);
   localparam int R_W   = FRAC_BITS + 2;
   localparam int XW    = 2 * R_W;
   localparam int RM    = R_W + 3;
   localparam int MAG_W = FRAC_BITS + 3;

   ctl_type          ctl_ff  [R_W];
   logic [RM-1:0]    rem_ff  [R_W];
   logic [R_W-1:0]   root_ff [R_W];
   logic [XW-1:0]    x_ff    [R_W];
   logic [MAG_W-1:0] mag_ff  [R_W][3];

   for (genvar s = 0; s < R_W; s++) begin : g_stage
      ctl_type          ctl_cur;
      logic [RM-1:0]    rem_cur;
      logic [R_W-1:0]   root_cur;
      logic [XW-1:0]    x_cur;
      logic [MAG_W-1:0] mag_cur [3];
      logic [RM-1:0]    rem2;
      logic [RM-1:0]    trial;
      logic             fits;
      logic [RM-1:0]    rem_in;
      logic [R_W-1:0]   root_in;
      logic [XW-1:0]    x_in;

      if (s == 0) begin : g_head
         assign ctl_cur  = ctl_i;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign x_cur    = {1'b0, rad_i, {FRAC_BITS{1'b0}}};
         assign mag_cur  = mag_i;
      end else begin : g_link
         assign ctl_cur  = ctl_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign x_cur    = x_ff[s-1];
         assign mag_cur  = mag_ff[s-1];
      end

      // Bring down two radicand bits and try the next root bit
      always_comb begin
         rem2    = {rem_cur[RM-3:0], x_cur[XW-1 -: 2]};
         trial   = {1'b0, root_cur, 2'b01};
         fits    = (rem2 >= trial);
         rem_in  = fits ? (rem2 - trial) : rem2;
         root_in = {root_cur[R_W-2:0], fits};
         x_in    = {x_cur[XW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= CTL_IDLE;
         end else if (en) begin
            ctl_ff[s] <= ctl_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            x_ff[s]    <= x_in;
            mag_ff[s]  <= mag_cur;
         end
      end
   end

   assign ctl_o  = ctl_ff[R_W-1];
   assign root_o = root_ff[R_W-1];
   assign mag_o  = mag_ff[R_W-1];

endmodule

`default_nettype wire

FILE: rtl/rm2q_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rm2q_div import rm2q_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  ctl_type                ctl_i,
   input  logic [FRAC_BITS+1:0]   r_i,
   input  logic [FRAC_BITS+2:0]   mag_i [3],
   output ctl_type                ctl_o,
   output logic [FRAC_BITS+1:0]   r_o,
   output logic [2*FRAC_BITS+1:0] quo_o [3]
);
   localparam int R_W = FRAC_BITS + 2;
   localparam int QW  = 2 * FRAC_BITS + 2;

   ctl_type        ctl_ff [QW];
   logic [R_W-1:0] r_ff   [QW];
   logic [R_W:0]   rem_ff [QW][3];
   logic [QW-1:0]  n_ff   [QW][3];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      ctl_type        ctl_cur;
      logic [R_W-1:0] r_cur;
      logic [R_W:0]   rem_cur [3];
      logic [QW-1:0]  n_cur   [3];
      logic [R_W:0]   rem2    [3];
      logic           fits    [3];
      logic [R_W:0]   rem_in  [3];
      logic [QW-1:0]  n_in    [3];

      if (s == 0) begin : g_head
         assign ctl_cur = ctl_i;
         assign r_cur   = r_i;
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_cur[l] = '0;
            assign n_cur[l]   = {mag_i[l], {(FRAC_BITS-1){1'b0}}};
         end
      end else begin : g_link
         assign ctl_cur = ctl_ff[s-1];
         assign r_cur   = r_ff[s-1];
         assign rem_cur = rem_ff[s-1];
         assign n_cur   = n_ff[s-1];
      end

      // Shift in the next dividend bit, subtract the root where it fits
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rem2[l]   = {rem_cur[l][R_W-1:0], n_cur[l][QW-1]};
            fits[l]   = (rem2[l] >= {1'b0, r_cur});
            rem_in[l] = fits[l] ? (rem2[l] - {1'b0, r_cur}) : rem2[l];
            n_in[l]   = {n_cur[l][QW-2:0], fits[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= CTL_IDLE;
         end else if (en) begin
            ctl_ff[s] <= ctl_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= r_cur;
            rem_ff[s] <= rem_in;
            n_ff[s]   <= n_in;
         end
      end
   end

   assign ctl_o = ctl_ff[QW-1];
   assign r_o   = r_ff[QW-1];
   assign quo_o = n_ff[QW-1];

endmodule

`default_nettype wire

FILE: rtl/rm2q_back.sv
// Back stage: place parts, fix the sign, saturate and register the result.
`default_nettype none

module rm2q_back import rm2q_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  ctl_type                    ctl_i,
   input  logic [FRAC_BITS+1:0]       r_i,
   input  logic [2*FRAC_BITS+1:0]     quo_i [3],
   output logic                       valid_o,
   output logic signed [FRAC_BITS+1:0] qx_o,
   output logic signed [FRAC_BITS+1:0] qy_o,
   output logic signed [FRAC_BITS+1:0] qz_o,
   output logic [FRAC_BITS:0]         qw_o,
   output logic                       clipped_o
);
   localparam int QW = 2 * FRAC_BITS + 2;
   localparam int VW = QW + 2;
   localparam int OW = FRAC_BITS + 2;
   localparam logic signed [VW-1:0] ONE = VW'(1) << FRAC_BITS;

   logic [VW-1:0]        mag_ext [3];
   logic signed [VW-1:0] sv [3];
   logic signed [VW-1:0] piv_v;
   logic signed [VW-1:0] qv [4];
   logic signed [VW-1:0] cv [4];
   logic                 flip;
   logic                 clip_in;
   logic                 valid_ff;
   logic signed [OW-1:0] qx_ff, qy_ff, qz_ff;
   logic [OW-2:0]        qw_ff;
   logic                 clipped_ff;

   // Apply numerator signs, zero the parts when the pivot root is zero
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag_ext[l] = VW'(quo_i[l]);
         sv[l]      = ctl_i.neg[l] ? (VW'(0) - mag_ext[l]) : mag_ext[l];
         if (ctl_i.sel != PIV_TRACE && r_i == '0) begin
            sv[l] = '0;
         end
      end
      piv_v = VW'(r_i >> 1);
   end

   // Route lanes to quaternion parts (x, y, z, w)
   always_comb begin
      unique case (ctl_i.sel)
         PIV_X: begin
            qv[0] = piv_v; qv[1] = sv[1]; qv[2] = sv[2]; qv[3] = sv[0];
         end
         PIV_Y: begin
            qv[0] = sv[2]; qv[1] = piv_v; qv[2] = sv[1]; qv[3] = sv[0];
         end
         PIV_Z: begin
            qv[0] = sv[1]; qv[1] = sv[2]; qv[2] = piv_v; qv[3] = sv[0];
         end
         default: begin
            qv[0] = sv[0]; qv[1] = sv[1]; qv[2] = sv[2]; qv[3] = piv_v;
         end
      endcase
   end

   // Keep the scalar non-negative, then saturate to plus or minus one
   always_comb begin
      flip    = (ctl_i.sel != PIV_TRACE) && (qv[3] < 0);
      clip_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         cv[k] = flip ? -qv[k] : qv[k];
         if (cv[k] > ONE) begin
            cv[k]   = ONE;
            clip_in = 1'b1;
         end else if (cv[k] < -ONE) begin
            cv[k]   = -ONE;
            clip_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff      <= cv[0][OW-1:0];
         qy_ff      <= cv[1][OW-1:0];
         qz_ff      <= cv[2][OW-1:0];
         qw_ff      <= cv[3][OW-2:0];
         clipped_ff <= clip_in;
      end
   end

   assign valid_o   = valid_ff;
   assign qx_o      = qx_ff;
   assign qy_o      = qy_ff;
   assign qz_o      = qz_ff;
   assign qw_o      = qw_ff;
   assign clipped_o = clipped_ff;

endmodule

`default_nettype wire

FILE: verif/rm2q_tb.sv
// Testbench for the rotation matrix to quaternion converter: directed and random matrices.
`default_nettype none

module tb import rm2q_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB  = FRAC_BITS_DEF;
   localparam int IW  = FB + 2;
   localparam int WW  = FB + 1;
   localparam longint ONE = longint'(1) << FB;
   localparam int LATENCY = 3 * FB + 6;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [IW-1:0] qx, qy, qz;
      logic        [WW-1:0] qw;
      logic                 clipped;
   } quat_type;

   typedef logic signed [IW-1:0] matrix_type [3][3];

   // Integer square root, floor
   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // d * (ONE/2) / r, truncated toward zero
   function automatic longint scaled_ratio(longint d, longint unsigned r);
      longint unsigned mag, quo;
      mag = (d < 0) ? longint'(-d) : d;
      quo = (mag << (FB - 1)) / r;
      return (d < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   function automatic quat_type convert_matrix(matrix_type mi);
      longint m [3][3];
      longint q [4];
      longint tr, rad;
      longint unsigned r;
      int i, j, k;
      bit clip;
      quat_type res;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++) m[a][b] = mi[a][b];
      q = '{0, 0, 0, 0};
      clip = 0;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         r = root_floor(longint'(tr + ONE) << FB);
         q[3] = r >> 1;
         q[0] = scaled_ratio(m[1][2] - m[2][1], r);
         q[1] = scaled_ratio(m[2][0] - m[0][2], r);
         q[2] = scaled_ratio(m[0][1] - m[1][0], r);
      end else begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         rad = m[i][i] - (m[j][j] + m[k][k]) + ONE;
         if (rad < 0) rad = 0;
         r = root_floor(longint'(rad) << FB);
         q[i] = r >> 1;
         if (r != 0) begin
            q[3] = scaled_ratio(m[j][k] - m[k][j], r);
            q[j] = scaled_ratio(m[i][j] + m[j][i], r);
            q[k] = scaled_ratio(m[i][k] + m[k][i], r);
         end
         if (q[3] < 0)
            for (int a = 0; a < 4; a++) q[a] = -q[a];
      end
      // clamp to plus or minus one
      for (int a = 0; a < 4; a++) begin
         if (q[a] > ONE) begin q[a] = ONE; clip = 1; end
         if (q[a] < -ONE) begin q[a] = -ONE; clip = 1; end
      end
      res.qx = q[0][IW-1:0];
      res.qy = q[1][IW-1:0];
      res.qz = q[2][IW-1:0];
      res.qw = q[3][WW-1:0];
      res.clipped = clip;
      return res;
   endfunction

   class quat_scoreboard;
      quat_type pending [$];
      int mismatches = 0;
      int checked = 0;

      function void note_matrix(matrix_type mi);
         pending.push_back(convert_matrix(mi));
      endfunction

      function void check_quat(quat_type got);
         quat_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected quaternion %h", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: qx %0d/%0d qy %0d/%0d qz %0d/%0d qw %0d/%0d clip %0b/%0b",
                  want.qx, got.qx, want.qy, got.qy, want.qz, got.qz,
                  want.qw, got.qw, want.clipped, got.clipped);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   rm2q_req_if #(.FRAC_BITS(FB)) req_if ();
   rm2q_rsp_if #(.FRAC_BITS(FB)) rsp_if ();

   rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   quat_scoreboard board = new();
   int idle_cycles = 0;
   int sent = 0;
   bit timed_out = 0;
   bit stall_free = 0;

   // Random gap: mostly short, a few long
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (stall_free || p < 40) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Check each response transaction; count idle cycles for the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            board.check_quat('{rsp_if.qx, rsp_if.qy, rsp_if.qz, rsp_if.qw, rsp_if.clipped});
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Response stalls at the falling edge
   initial begin
      int g;
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         g = gap_len();
         if (g == 0) rsp_if.ready <= 1;
         else begin
            rsp_if.ready <= 0;
            repeat (g - 1) @(negedge clock);
         end
      end
   end

   // Watchdog
   initial begin
      forever begin
         @(posedge clock);
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Drive one matrix and hold it until accepted
   task automatic send_matrix(matrix_type mi);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_if.valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_if.valid <= 1;
      {req_if.m00, req_if.m01, req_if.m02} <= {mi[0][0], mi[0][1], mi[0][2]};
      {req_if.m10, req_if.m11, req_if.m12} <= {mi[1][0], mi[1][1], mi[1][2]};
      {req_if.m20, req_if.m21, req_if.m22} <= {mi[2][0], mi[2][1], mi[2][2]};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_matrix(mi);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [IW-1:0] rand_elem();
      int p;
      p = $urandom_range(99);
      if (p < 80) return IW'($urandom_range(131072) - 65536);
      if (p < 90) return IW'($urandom);
      case ($urandom_range(3))
         0: return IW'(ONE);
         1: return IW'(-ONE);
         2: return 0;
         default: return {1'b0, {(IW-1){1'b1}}};
      endcase
   endfunction

   // Approximate rotation: random angle about a random axis, from its cosine and sine
   function automatic matrix_type rand_rotation();
      matrix_type mi;
      real th, c, s, ax, ay, az, n;
      ax = $urandom_range(2000) - 1000.0;
      ay = $urandom_range(2000) - 1000.0;
      az = $urandom_range(2000) - 1000.0;
      n = $sqrt(ax * ax + ay * ay + az * az);
      if (n < 1.0) begin ax = 1; n = 1; end
      ax /= n; ay /= n; az /= n;
      th = ($urandom_range(62832) / 10000.0);
      c = $cos(th); s = $sin(th);
      mi[0][0] = IW'($rtoi((c + ax * ax * (1 - c)) * ONE));
      mi[0][1] = IW'($rtoi((ax * ay * (1 - c) - az * s) * ONE));
      mi[0][2] = IW'($rtoi((ax * az * (1 - c) + ay * s) * ONE));
      mi[1][0] = IW'($rtoi((ay * ax * (1 - c) + az * s) * ONE));
      mi[1][1] = IW'($rtoi((c + ay * ay * (1 - c)) * ONE));
      mi[1][2] = IW'($rtoi((ay * az * (1 - c) - ax * s) * ONE));
      mi[2][0] = IW'($rtoi((az * ax * (1 - c) - ay * s) * ONE));
      mi[2][1] = IW'($rtoi((az * ay * (1 - c) + ax * s) * ONE));
      mi[2][2] = IW'($rtoi((c + az * az * (1 - c)) * ONE));
      return mi;
   endfunction

   function automatic matrix_type diag_matrix(longint a, longint b, longint c);
      matrix_type mi;
      for (int r = 0; r < 3; r++)
         for (int q = 0; q < 3; q++) mi[r][q] = 0;
      mi[0][0] = IW'(a); mi[1][1] = IW'(b); mi[2][2] = IW'(c);
      return mi;
   endfunction

   initial begin
      matrix_type mi;
      req_if.valid = 0;
      {req_if.m00, req_if.m01, req_if.m02} = '0;
      {req_if.m10, req_if.m11, req_if.m12} = '0;
      {req_if.m20, req_if.m21, req_if.m22} = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: identity, half turns about each axis, ties, zero trace, extremes
      send_matrix(diag_matrix(ONE, ONE, ONE));
      send_matrix(diag_matrix(ONE, -ONE, -ONE));
      send_matrix(diag_matrix(-ONE, ONE, -ONE));
      send_matrix(diag_matrix(-ONE, -ONE, ONE));
      send_matrix(diag_matrix(0, 0, 0));
      send_matrix(diag_matrix(-ONE, -ONE, -ONE));
      send_matrix(diag_matrix(-ONE, -ONE, -ONE / 2));
      send_matrix(diag_matrix(ONE / 4, ONE / 4, -ONE));
      send_matrix(diag_matrix(-ONE, ONE / 4, ONE / 4));
      for (int p = 0; p < 4; p++) begin
         for (int r = 0; r < 3; r++)
            for (int q = 0; q < 3; q++)
               case (p)
                  0: mi[r][q] = IW'(ONE);
                  1: mi[r][q] = IW'(-ONE);
                  2: mi[r][q] = {1'b0, {(IW-1){1'b1}}};
                  default: mi[r][q] = {1'b1, {(IW-1){1'b0}}};
               endcase
         send_matrix(mi);
      end
      // Large off-diagonals of both signs; the last matrix drives qx to exactly one
      mi = diag_matrix(-ONE, -ONE, -ONE + 8);
      mi[0][1] = IW'(ONE); mi[1][0] = IW'(-ONE);
      send_matrix(mi);
      mi = diag_matrix(-ONE + 8, -ONE, -ONE);
      mi[1][2] = IW'(-ONE); mi[2][1] = IW'(ONE); mi[0][1] = IW'(ONE); mi[1][0] = IW'(ONE);
      send_matrix(mi);
      mi = diag_matrix(1, 0, 0);
      mi[1][2] = IW'(ONE); mi[2][1] = IW'(-ONE);
      send_matrix(mi);

      // Pause until every pending result has arrived
      req_if.valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);

      // Random: mostly rotations, some noise; one stretch without stalls
      for (int n = 0; n < 1150; n++) begin
         stall_free = (n >= 400 && n < 550);
         if ($urandom_range(99) < 65) mi = rand_rotation();
         else
            for (int r = 0; r < 3; r++)
               for (int q = 0; q < 3; q++) mi[r][q] = rand_elem();
         send_matrix(mi);
         if (n == 700) begin
            req_if.valid <= 0;
            while (board.pending.size() != 0) @(negedge clock);
         end
      end
      stall_free = 0;
      req_if.valid <= 0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);

      $display("Converted %0d matrices (trace and pivot cases, ties, saturation),", sent);
      $display("checked %0d quaternions with random stalls on both channels.", board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/rm2q_pkg.sv
rtl/rm2q_if.sv
rtl/rm2q_front.sv
rtl/rm2q_sqrt.sv
rtl/rm2q_div.sv
rtl/rm2q_back.sv
rtl/rotation_matrix_to_quaternion.sv
verif/rm2q_tb.sv
